### design/ths_pkg.sv
// Shared types and constants for the timer heap scheduler.
package ths_pkg;

  localparam int MAX_TIMERS_DEF  = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int ORDER_BITS_DEF  = 32;
  localparam int MAX_RESULTS     = 16;
  localparam int ID_BITS         = 4;
  localparam int REQ_BITS        = 2;
  localparam int CAP_BITS        = 5;
  localparam int NRES_BITS       = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_BITS       = $clog2(MAX_RESULTS);

  localparam logic [REQ_BITS-1:0] REQ_SET    = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_TICK   = 2'd2;

  localparam logic [CAP_BITS-1:0] CAP_RESET  = CAP_BITS'(MAX_RESULTS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP,
    ST_DOWN_L,
    ST_DOWN_R,
    ST_TICK,
    ST_REARM,
    ST_FINISH,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    RET_FINISH,
    RET_REARM,
    RET_TICK
  } ret_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SET_PERIOD,
    CMD_SET_REARM,
    CMD_SET_NEW,
    CMD_SET_DISARM,
    CMD_DISARM,
    CMD_UP,
    CMD_DOWN_L,
    CMD_DOWN_R,
    CMD_POP,
    CMD_REARM,
    CMD_FINISH,
    CMD_SEND
  } cmd_t;

  typedef struct packed {
    logic req_set;
    logic req_cancel;
    logic req_tick;
    logic id_ok;
    logic ft_zero;
    logic armed;
    logic rm_fix;
    logic up_swap;
    logic moved;
    logic down_stop;
    logic tick_go;
    logic rearm;
    logic out_last;
  } stat_t;

endpackage

### design/timer_heap_scheduler.sv
// Top level of the timer heap scheduler: controller and heap datapath.
//
//  channel | direction | handshake          | words per request
//  in_     | input     | in_valid/in_stall  | one
//  out_    | output    | out_valid/out_stall| one per fired timer, or one if none
//  cfg_    | input     | cfg_wr_en          | one write, no reply
//
// A request is taken only when the block is idle, and its results follow after it.
// Set and cancel are decoded, sift the heap where needed and finish before the first result;
// a sift swaps upward level by level, and on the way down checks the left and then the right
// child at each level. A tick makes a due check and a re-arm step for each fired timer, plus
// the sifts of its removal and re-insertion; the fire cap bounds the count, and the single
// comparator sets this pace.
// Reset is synchronous: it empties the heap and disarms all timers.
// A stalled result holds its word; the block takes no request until the last is taken.
module timer_heap_scheduler #(
  parameter int MAX_TIMERS = ths_pkg::MAX_TIMERS_DEF,
  parameter int TIME_BITS  = ths_pkg::TIME_BITS_DEF,
  parameter int ORDER_BITS = ths_pkg::ORDER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ths_pkg::REQ_BITS-1:0] in_req_type,
  input  logic [ths_pkg::ID_BITS-1:0]  in_timer_id,
  input  logic [TIME_BITS-1:0]         in_fire_time,
  input  logic [TIME_BITS-1:0]         in_repeat_interval,
  input  logic [TIME_BITS-1:0]         in_now_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_fired_valid,
  output logic [ths_pkg::ID_BITS-1:0]  out_fired_id,
  output logic [TIME_BITS-1:0]         out_fired_at,
  output logic                         out_last_result,
  output logic                         out_deadline_valid,
  output logic [TIME_BITS-1:0]         out_next_deadline,
  input  logic                         cfg_wr_en,
  input  logic [ths_pkg::CAP_BITS-1:0] cfg_wr_data
);
  import ths_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ths_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ths_dp #(
    .MAX_TIMERS (MAX_TIMERS),
    .TIME_BITS  (TIME_BITS),
    .ORDER_BITS (ORDER_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_req_type        (in_req_type),
    .in_timer_id        (in_timer_id),
    .in_fire_time       (in_fire_time),
    .in_repeat_interval (in_repeat_interval),
    .in_now_time        (in_now_time),
    .out_fired_valid    (out_fired_valid),
    .out_fired_id       (out_fired_id),
    .out_fired_at       (out_fired_at),
    .out_last_result    (out_last_result),
    .out_deadline_valid (out_deadline_valid),
    .out_next_deadline  (out_next_deadline)
  );

endmodule

### design/ths_dp.sv
// Datapath of the timer heap scheduler: heap storage, comparator and result buffer.
module ths_dp #(
  parameter int MAX_TIMERS = ths_pkg::MAX_TIMERS_DEF,
  parameter int TIME_BITS  = ths_pkg::TIME_BITS_DEF,
  parameter int ORDER_BITS = ths_pkg::ORDER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ths_pkg::cmd_t                cmd,
  output ths_pkg::stat_t               stat,
  input  logic                         cfg_wr_en,
  input  logic [ths_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  logic [ths_pkg::REQ_BITS-1:0] in_req_type,
  input  logic [ths_pkg::ID_BITS-1:0]  in_timer_id,
  input  logic [TIME_BITS-1:0]         in_fire_time,
  input  logic [TIME_BITS-1:0]         in_repeat_interval,
  input  logic [TIME_BITS-1:0]         in_now_time,
  output logic                         out_fired_valid,
  output logic [ths_pkg::ID_BITS-1:0]  out_fired_id,
  output logic [TIME_BITS-1:0]         out_fired_at,
  output logic                         out_last_result,
  output logic                         out_deadline_valid,
  output logic [TIME_BITS-1:0]         out_next_deadline
);
  import ths_pkg::*;

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int LW = IW + 2;
  localparam logic [ORDER_BITS-1:0] OHALF = ORDER_BITS'((64'(1) << (ORDER_BITS - 1)) - 64'(1));

  logic [IW-1:0]         slots_r  [MAX_TIMERS];
  logic [IW-1:0]         posof_r  [MAX_TIMERS];
  logic [TIME_BITS-1:0]  armt_r   [MAX_TIMERS];
  logic [TIME_BITS-1:0]  period_r [MAX_TIMERS];
  logic [ORDER_BITS-1:0] order_r  [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] armv_r;
  logic [CW-1:0]         count_r;
  logic [ORDER_BITS-1:0] ocnt_r;
  logic [IW-1:0]         pos_r;
  logic [IW-1:0]         best_r;
  logic                  moved_r;
  logic [IW-1:0]         tid_r;
  logic [REQ_BITS-1:0]   req_r;
  logic [ID_BITS-1:0]    rawid_r;
  logic [TIME_BITS-1:0]  ft_r;
  logic [TIME_BITS-1:0]  rep_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [CAP_BITS-1:0]   maxf_r;
  logic [NRES_BITS-1:0]  nres_r;
  logic [NRES_BITS-1:0]  idx_r;
  logic [ID_BITS-1:0]    rbid_r [MAX_RESULTS];
  logic [TIME_BITS-1:0]  rbat_r [MAX_RESULTS];
  logic                  dv_r;
  logic [TIME_BITS-1:0]  dl_r;

  logic [IW-1:0]         rid;
  logic [IW-1:0]         parent;
  logic [LW-1:0]         lpos;
  logic [LW-1:0]         rpos;
  logic                  l_in;
  logic                  r_in;
  logic [IW-1:0]         a_id;
  logic [IW-1:0]         b_id;
  logic [ORDER_BITS-1:0] odiff;
  logic                  first;
  logic [IW-1:0]         best_nxt;
  logic [IW-1:0]         rm_pos;
  logic [CW-1:0]         newc;
  logic [IW-1:0]         last_id;
  logic [IW-1:0]         head_id;
  logic [TIME_BITS-1:0]  head_t;
  logic [NRES_BITS-1:0]  cap;
  logic [TIME_BITS-1:0]  nt;
  logic [IW-1:0]         ins_id;
  logic                  rm_fix;

  assign rid    = IW'(rawid_r);
  assign parent = IW'((pos_r - IW'(1)) >> 1);
  assign lpos   = {1'b0, pos_r, 1'b1};
  assign rpos   = lpos + LW'(1);
  assign l_in   = lpos < LW'(count_r);
  assign r_in   = rpos < LW'(count_r);

  always_comb begin
    case (cmd)
      CMD_UP: begin
        a_id = slots_r[pos_r];
        b_id = slots_r[parent];
      end
      CMD_DOWN_L: begin
        a_id = slots_r[lpos[IW-1:0]];
        b_id = slots_r[pos_r];
      end
      CMD_DOWN_R: begin
        a_id = slots_r[rpos[IW-1:0]];
        b_id = slots_r[best_r];
      end
      default: begin
        a_id = slots_r[pos_r];
        b_id = slots_r[pos_r];
      end
    endcase
  end

  assign odiff = order_r[b_id] - order_r[a_id];

  always_comb begin
    if (armt_r[a_id] != armt_r[b_id]) begin
      first = armt_r[a_id] < armt_r[b_id];
    end else if (odiff == '0) begin
      first = a_id < b_id;
    end else begin
      first = odiff < OHALF;
    end
  end

  always_comb begin
    if (cmd == CMD_DOWN_L) begin
      best_nxt = (l_in && first) ? lpos[IW-1:0] : pos_r;
    end else begin
      best_nxt = (r_in && first) ? rpos[IW-1:0] : best_r;
    end
  end

  assign head_id = slots_r[0];
  assign head_t  = armt_r[head_id];
  assign rm_pos  = (cmd == CMD_POP) ? '0 : posof_r[rid];
  assign newc    = count_r - CW'(1);
  assign last_id = slots_r[newc[IW-1:0]];
  assign rm_fix  = CW'(rm_pos) < newc;
  assign nt      = now_r + period_r[tid_r];
  assign ins_id  = (cmd == CMD_REARM) ? tid_r : rid;

  always_comb begin
    if (maxf_r == '0) begin
      cap = NRES_BITS'(1);
    end else if (32'(maxf_r) > MAX_RESULTS) begin
      cap = NRES_BITS'(MAX_RESULTS);
    end else begin
      cap = NRES_BITS'(maxf_r);
    end
  end

  always_comb begin
    stat.req_set    = req_r == REQ_SET;
    stat.req_cancel = req_r == REQ_CANCEL;
    stat.req_tick   = req_r == REQ_TICK;
    stat.id_ok      = 32'(rawid_r) < MAX_TIMERS;
    stat.ft_zero    = ft_r == '0;
    stat.armed      = armv_r[rid];
    stat.rm_fix     = rm_fix;
    stat.up_swap    = (pos_r != '0) && first;
    stat.moved      = moved_r;
    stat.down_stop  = best_nxt == pos_r;
    stat.tick_go    = (count_r != '0) && (nres_r < cap) && (head_t <= now_r);
    stat.rearm      = (period_r[tid_r] != '0) && (nt != '0);
    stat.out_last   = (nres_r == '0) || (idx_r == nres_r - NRES_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxf_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      maxf_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armv_r  <= '0;
      count_r <= '0;
      ocnt_r  <= '0;
      nres_r  <= '0;
      idx_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      case (cmd)
        CMD_LATCH: begin
          req_r   <= in_req_type;
          rawid_r <= in_timer_id;
          ft_r    <= in_fire_time;
          rep_r   <= in_repeat_interval;
          now_r   <= in_now_time;
          nres_r  <= '0;
        end
        CMD_SET_PERIOD: begin
          period_r[rid] <= rep_r;
        end
        CMD_SET_REARM: begin
          period_r[rid] <= rep_r;
          armt_r[rid]   <= ft_r;
          pos_r         <= posof_r[rid];
          moved_r       <= 1'b0;
        end
        CMD_SET_NEW, CMD_REARM: begin
          if (cmd == CMD_SET_NEW) begin
            period_r[rid] <= rep_r;
            armt_r[rid]   <= ft_r;
          end else begin
            armt_r[tid_r] <= nt;
          end
          armv_r[ins_id]            <= 1'b1;
          slots_r[count_r[IW-1:0]]  <= ins_id;
          posof_r[ins_id]           <= count_r[IW-1:0];
          order_r[ins_id]           <= ocnt_r;
          ocnt_r                    <= ocnt_r + ORDER_BITS'(1);
          count_r                   <= count_r + CW'(1);
          pos_r                     <= count_r[IW-1:0];
          moved_r                   <= 1'b1;
        end
        CMD_SET_DISARM, CMD_DISARM, CMD_POP: begin
          if (cmd == CMD_SET_DISARM) begin
            period_r[rid] <= rep_r;
          end
          if (cmd == CMD_POP) begin
            armv_r[head_id]            <= 1'b0;
            tid_r                      <= head_id;
            rbid_r[nres_r[RIDX_BITS-1:0]] <= ID_BITS'(head_id);
            rbat_r[nres_r[RIDX_BITS-1:0]] <= head_t;
            nres_r                     <= nres_r + NRES_BITS'(1);
          end else begin
            armv_r[rid] <= 1'b0;
          end
          count_r <= newc;
          if (rm_fix) begin
            slots_r[rm_pos]  <= last_id;
            posof_r[last_id] <= rm_pos;
            pos_r            <= rm_pos;
            moved_r          <= 1'b0;
          end
        end
        CMD_UP: begin
          if (stat.up_swap) begin
            slots_r[pos_r]  <= slots_r[parent];
            slots_r[parent] <= slots_r[pos_r];
            posof_r[a_id]   <= parent;
            posof_r[b_id]   <= pos_r;
            pos_r           <= parent;
            moved_r         <= 1'b1;
          end
        end
        CMD_DOWN_L: begin
          best_r <= best_nxt;
        end
        CMD_DOWN_R: begin
          if (best_nxt != pos_r) begin
            slots_r[pos_r]          <= slots_r[best_nxt];
            slots_r[best_nxt]       <= slots_r[pos_r];
            posof_r[slots_r[pos_r]] <= best_nxt;
            posof_r[slots_r[best_nxt]] <= pos_r;
            pos_r                   <= best_nxt;
          end
        end
        CMD_FINISH: begin
          idx_r <= '0;
          dv_r  <= count_r != '0;
          dl_r  <= (count_r != '0) ? head_t : '0;
        end
        CMD_SEND: begin
          idx_r <= idx_r + NRES_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_fired_valid    = nres_r != '0;
  assign out_fired_id       = (nres_r != '0) ? rbid_r[idx_r[RIDX_BITS-1:0]] : '0;
  assign out_fired_at       = (nres_r != '0) ? rbat_r[idx_r[RIDX_BITS-1:0]] : '0;
  assign out_last_result    = stat.out_last;
  assign out_deadline_valid = dv_r;
  assign out_next_deadline  = dl_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_TIMERS)
    else $error("Heap count exceeds the number of timers.");

  a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nres_r) <= MAX_RESULTS)
    else $error("Result buffer overflow.");

  a_pop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_POP |=> !armv_r[tid_r])
    else $error("Popped timer is still marked armed.");

  a_pos_track: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_DOWN_L |-> posof_r[slots_r[pos_r]] == pos_r)
    else $error("Position table out of step with the heap.");

endmodule

### design/ths_ctrl.sv
// Controller state machine that sequences requests over the heap datapath.
module ths_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ths_pkg::stat_t stat,
  output ths_pkg::cmd_t  cmd
);
  import ths_pkg::*;

  state_t state_r;
  state_t state_nxt;
  ret_t   ret_r;
  ret_t   ret_nxt;
  state_t ret_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= RET_FINISH;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    case (ret_r)
      RET_REARM: ret_state = ST_REARM;
      RET_TICK:  ret_state = ST_TICK;
      default:   ret_state = ST_FINISH;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = CMD_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd       = CMD_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ret_nxt   = RET_FINISH;
        state_nxt = ST_FINISH;
        if (stat.req_set && stat.id_ok) begin
          if (stat.ft_zero) begin
            if (stat.armed) begin
              cmd       = CMD_SET_DISARM;
              state_nxt = stat.rm_fix ? ST_UP : ST_FINISH;
            end else begin
              cmd = CMD_SET_PERIOD;
            end
          end else if (stat.armed) begin
            cmd       = CMD_SET_REARM;
            state_nxt = ST_UP;
          end else begin
            cmd       = CMD_SET_NEW;
            state_nxt = ST_UP;
          end
        end else if (stat.req_cancel && stat.id_ok && stat.armed) begin
          cmd       = CMD_DISARM;
          state_nxt = stat.rm_fix ? ST_UP : ST_FINISH;
        end else if (stat.req_tick) begin
          state_nxt = ST_TICK;
        end
      end
      ST_UP: begin
        cmd = CMD_UP;
        if (!stat.up_swap) begin
          state_nxt = stat.moved ? ret_state : ST_DOWN_L;
        end
      end
      ST_DOWN_L: begin
        cmd       = CMD_DOWN_L;
        state_nxt = ST_DOWN_R;
      end
      ST_DOWN_R: begin
        cmd       = CMD_DOWN_R;
        state_nxt = stat.down_stop ? ret_state : ST_DOWN_L;
      end
      ST_TICK: begin
        if (stat.tick_go) begin
          cmd       = CMD_POP;
          ret_nxt   = RET_REARM;
          state_nxt = stat.rm_fix ? ST_UP : ST_REARM;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_REARM: begin
        state_nxt = ST_TICK;
        if (stat.rearm) begin
          cmd       = CMD_REARM;
          ret_nxt   = RET_TICK;
          state_nxt = ST_UP;
        end
      end
      ST_FINISH: begin
        cmd       = CMD_FINISH;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd       = CMD_SEND;
          state_nxt = stat.out_last ? ST_IDLE : ST_SEND;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_out_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("Result offered while a request can be taken.");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_DECODE)
    else $error("Accepted word was not decoded.");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && stat.out_last) |=> !out_valid)
    else $error("Result channel kept sending after the last word.");

endmodule

### dv/tb_timer_heap_scheduler.sv
// Self-checking testbench for the timer heap scheduler with its own heap predictor.
module tb_timer_heap_scheduler;
  import ths_pkg::*;

  localparam int TB = 48;
  localparam int NT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic          fired_valid;
    logic [3:0]    fired_id;
    logic [TB-1:0] fired_at;
    logic          last_result;
    logic          deadline_valid;
    logic [TB-1:0] next_deadline;
  } fire_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_BITS-1:0] in_req_type = '0;
  logic [ID_BITS-1:0] in_timer_id = '0;
  logic [TB-1:0] in_fire_time = '0;
  logic [TB-1:0] in_repeat_interval = '0;
  logic [TB-1:0] in_now_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_fired_valid;
  logic [ID_BITS-1:0] out_fired_id;
  logic [TB-1:0] out_fired_at;
  logic out_last_result;
  logic out_deadline_valid;
  logic [TB-1:0] out_next_deadline;
  logic cfg_wr_en = 1'b0;
  logic [CAP_BITS-1:0] cfg_wr_data = '0;

  timer_heap_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_timer_id(in_timer_id),
    .in_fire_time(in_fire_time), .in_repeat_interval(in_repeat_interval),
    .in_now_time(in_now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_fired_valid(out_fired_valid), .out_fired_id(out_fired_id),
    .out_fired_at(out_fired_at), .out_last_result(out_last_result),
    .out_deadline_valid(out_deadline_valid), .out_next_deadline(out_next_deadline),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted scheduler state.
  logic [3:0]    slot_id[NT];
  int            heap_size;
  logic [TB-1:0] armed_at[NT];
  logic [TB-1:0] interval[NT];
  logic [31:0]   seq_no[NT];
  logic [31:0]   seq_next;
  logic [4:0]    fire_cap;

  fire_word_t expected_fires[$];
  int mismatches = 0;
  int watchdog = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  int hold_cycles = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_ack = 1'b0;

  function automatic bit earlier(int a, int b);
    logic [31:0] d;
    if (armed_at[a] != armed_at[b]) return armed_at[a] < armed_at[b];
    d = seq_no[b] - seq_no[a];
    if (d == 0) return a < b;
    return d < 32'h7FFF_FFFF;
  endfunction

  function automatic void swap_pos(int i, int j);
    logic [3:0] t;
    t = slot_id[i];
    slot_id[i] = slot_id[j];
    slot_id[j] = t;
  endfunction

  function automatic void bubble_up(int p);
    int q;
    while (p > 0) begin
      q = (p - 1) / 2;
      if (!earlier(slot_id[p], slot_id[q])) break;
      swap_pos(p, q);
      p = q;
    end
  endfunction

  function automatic void bubble_down(int p);
    int l, r, b;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      b = p;
      if (l < heap_size && earlier(slot_id[l], slot_id[b])) b = l;
      if (r < heap_size && earlier(slot_id[r], slot_id[b])) b = r;
      if (b == p) break;
      swap_pos(p, b);
      p = b;
    end
  endfunction

  function automatic void reheap(int p);
    if (p > 0 && earlier(slot_id[p], slot_id[(p - 1) / 2])) bubble_up(p);
    else bubble_down(p);
  endfunction

  function automatic int locate(int id);
    for (int i = 0; i < heap_size; i++) if (slot_id[i] == id) return i;
    return heap_size;
  endfunction

  function automatic void push_timer(int id);
    if (heap_size >= NT) return;
    seq_no[id] = seq_next;
    seq_next++;
    slot_id[heap_size] = 4'(id);
    heap_size++;
    bubble_up(heap_size - 1);
  endfunction

  function automatic void drop_at(int p);
    if (p >= heap_size) return;
    heap_size--;
    if (p < heap_size) begin
      slot_id[p] = slot_id[heap_size];
      reheap(p);
    end
  endfunction

  function automatic void stop_timer(int id);
    if (armed_at[id] == 0) return;
    drop_at(locate(id));
    armed_at[id] = '0;
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < NT; i++) begin
      armed_at[i] = '0;
      interval[i] = '0;
      seq_no[i] = '0;
      slot_id[i] = '0;
    end
    heap_size = 0;
    seq_next = '0;
    fire_cap = 5'd16;
  endfunction

  function automatic void predict_fires(logic [1:0] req, logic [3:0] id, logic [TB-1:0] ft,
                                        logic [TB-1:0] rep, logic [TB-1:0] now);
    fire_word_t w[$];
    fire_word_t f;
    int lim, t, p;
    logic [TB-1:0] nt, at;
    if (req == REQ_SET) begin
      interval[id] = rep;
      if (ft == 0) stop_timer(id);
      else if (armed_at[id] != 0) begin
        p = locate(id);
        armed_at[id] = ft;
        if (p < heap_size) reheap(p);
      end else begin
        armed_at[id] = ft;
        push_timer(id);
      end
    end else if (req == REQ_CANCEL) begin
      stop_timer(id);
    end else if (req == REQ_TICK) begin
      lim = (fire_cap == 0) ? 1 : (fire_cap > 16 ? 16 : int'(fire_cap));
      while (heap_size > 0 && w.size() < lim && armed_at[slot_id[0]] <= now) begin
        t = int'(slot_id[0]);
        at = armed_at[t];
        nt = now + interval[t];
        drop_at(0);
        armed_at[t] = '0;
        if (interval[t] != 0 && nt != 0) begin
          armed_at[t] = nt;
          push_timer(t);
        end
        f = '0;
        f.fired_valid = 1'b1;
        f.fired_id = 4'(t);
        f.fired_at = at;
        w = {w, f};
      end
    end
    if (w.size() == 0) begin
      f = '0;
      w = {w, f};
    end
    foreach (w[k]) begin
      w[k].last_result = (k == w.size() - 1);
      w[k].deadline_valid = heap_size > 0;
      w[k].next_deadline = heap_size > 0 ? armed_at[slot_id[0]] : '0;
      expected_fires = {expected_fires, w[k]};
    end
  endfunction

  task automatic send_request(logic [1:0] req, logic [3:0] id, logic [TB-1:0] ft,
                              logic [TB-1:0] rep, logic [TB-1:0] now);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_timer_id <= id;
    in_fire_time <= ft;
    in_repeat_interval <= rep;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fires(req, id, ft, rep, now);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_fires.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cap(logic [4:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fire_cap = v;
  endtask

  function automatic logic [TB-1:0] rand_time();
    return TB'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    send_request(REQ_TICK, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    send_request(REQ_SET, 3, 48'hFFFF_FFFF_FFFF, 0, 0);
    send_request(REQ_SET, 0, 48'd100, 48'd50, 0);
    send_request(REQ_SET, 15, 48'd100, 0, 0);
    send_request(REQ_SET, 7, 48'd100, 48'hFFFF_FFFF_FFFF, 0);
    send_request(REQ_SET, 0, 48'd90, 48'd50, 0);
    send_request(REQ_CANCEL, 9, 0, 0, 0);
    send_request(2'd3, 4, 48'd5, 48'd5, 48'd5);
    send_request(REQ_TICK, 0, 0, 0, 48'd99);
    send_request(REQ_TICK, 0, 0, 0, 48'd100);
    send_request(REQ_SET, 5, 48'd10, 48'd1, 0);
    send_request(REQ_TICK, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    send_request(REQ_SET, 3, 0, 48'd7, 0);
    send_request(REQ_CANCEL, 3, 0, 0, 0);
    send_request(REQ_SET, 2, 48'd20, 48'hAAAA_AAAA_AAAA, 0);
    send_request(REQ_SET, 1, 48'd20, 48'h5555_5555_5555, 0);
    send_request(REQ_TICK, 0, 0, 0, 48'd20);
  endtask

  task automatic test_fire_cap();
    logic [4:0] caps[4] = '{5'd1, 5'd0, 5'd31, 5'd16};
    foreach (caps[c]) begin
      write_cap(caps[c]);
      for (int i = 0; i < 16; i++) begin
        send_request(REQ_SET, 4'(i), 48'd1 + TB'(i % 3), TB'(i % 2), 0);
      end
      send_request(REQ_TICK, 0, 0, 0, 48'd10);
      send_request(REQ_TICK, 0, 0, 0, 48'd20);
    end
    write_cap(5'd4);
  endtask

  task automatic test_random(int n, bit wide);
    logic [1:0] req;
    logic [TB-1:0] now, ft, rep;
    now = wide ? rand_time() : TB'($urandom_range(0, 100));
    for (int i = 0; i < n; i++) begin
      req = $urandom_range(0, 9) < 5 ? REQ_SET : ($urandom_range(0, 9) < 7 ? REQ_TICK
            : ($urandom_range(0, 5) == 0 ? 2'd3 : REQ_CANCEL));
      ft = wide ? rand_time() : now + TB'($urandom_range(0, 60));
      if ($urandom_range(0, 9) == 0) ft = '0;
      rep = wide ? rand_time() : TB'($urandom_range(0, 40));
      if ($urandom_range(0, 3) == 0) rep = '0;
      if (req == REQ_TICK) now = wide ? rand_time() : now + TB'($urandom_range(0, 30));
      send_request(req, 4'($urandom_range(0, 15)), ft, rep, now);
    end
  endtask

  task automatic test_backpressure();
    drain();
    long_hold_req = ~long_hold_req;
    for (int i = 0; i < 6; i++) send_request(REQ_SET, 4'(i), 48'd5, 48'd3, 0);
    for (int i = 0; i < 6; i++) send_request(REQ_TICK, 0, 0, 0, TB'(5 + 3 * i));
    drain();
  endtask

  always @(posedge clk) begin
    int len;
    if (long_hold_req != long_hold_ack) begin
      long_hold_ack <= long_hold_req;
      out_stall <= 1'b1;
      hold_rx <= 1'b1;
      hold_cycles <= LONG_HOLD;
    end else if (hold_rx) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles <= 1) hold_rx <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 8);
      out_stall <= 1'b1;
      hold_rx <= (len > 1);
      hold_cycles <= len - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    fire_word_t got, exp;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_fired_valid, out_fired_id, out_fired_at, out_last_result,
             out_deadline_valid, out_next_deadline};
      if (expected_fires.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        exp = expected_fires.pop_front();
        if (got != exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_schedule();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fire_cap();
    test_random(25, 1'b0);
    test_backpressure();
    write_cap(5'd16);
    test_random(15, 1'b1);
    write_cap(5'd2);
    quiet = 1'b1;
    test_random(20, 1'b0);
    drain();
    if (mismatches == 0 && expected_fires.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
